[hdl/kfcv_pkg.sv]
// Package: shared types and constants for the constant-velocity Kalman core.
`timescale 1ns / 1ps
package kfcv_pkg;
  localparam int REG_W   = 24;
  localparam int COV_W   = 40;
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 1;
  localparam logic [IDX_W-1:0] REG_PROC_NOISE = 1'b0;
  localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED, ST_DIV0, ST_DIV1, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
    ST_DONE
  } state_t;

  // Operation handshake between sequencer and serial multiplier.
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

[hdl/kfcv_mul.sv]
// Module: bit-serial signed multiplier, one multiplier bit per cycle, result >> FRAC truncated.
`timescale 1ns / 1ps
module kfcv_mul #(
  parameter int A_W  = 48,
  parameter int B_W  = 32,
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic                   busy,
  output logic signed [A_W+B_W-1:0] prod
);
  import kfcv_pkg::*;
  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(B_W + 1);

  logic [A_W-1:0] ma_r;
  logic [B_W-1:0] mb_r;
  logic [P_W-1:0] acc_r;
  logic [C_W-1:0] cnt_r;
  logic           neg_r;
  logic           busy_r;
  logic [P_W-1:0] mag;
  logic [P_W-1:0] shifted;

  // Shift-add over the multiplier magnitude, LSB first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      ma_r   <= a[A_W-1] ? A_W'(-a) : a;
      mb_r   <= b[B_W-1] ? B_W'(-b) : b;
      neg_r  <= a[A_W-1] ^ b[B_W-1];
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r >> 1)
             + (mb_r[0] ? ({{B_W{1'b0}}, ma_r} << (B_W - 1)) : '0);
      mb_r  <= mb_r >> 1;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == C_W'(B_W - 1)) busy_r <= 1'b0;
    end
  end

  assign mag     = acc_r;
  assign shifted = mag >> FRAC;
  assign busy    = busy_r;
  assign prod    = neg_r ? P_W'(-shifted) : P_W'(shifted);
endmodule

[hdl/kfcv_div.sv]
// Module: restoring serial divider producing a saturated Q gain, one quotient bit per cycle.
`timescale 1ns / 1ps
module kfcv_div #(
  parameter int FRAC = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [kfcv_pkg::COV_W-1:0] num,
  input  logic        [kfcv_pkg::COV_W-1:0] den,
  output logic                        busy,
  output logic signed [kfcv_pkg::OUT_W-1:0] quo
);
  import kfcv_pkg::*;
  // quotient bits needed: 32 (saturation) => produce up to OUT_W bits of (n<<FRAC)/d
  localparam int N_W = COV_W + FRAC;
  localparam int C_W = $clog2(N_W + 1);

  logic [N_W-1:0]   n_r;
  logic [COV_W:0]   rem_r;
  logic [N_W-1:0]   q_r;
  logic [COV_W-1:0] d_r;
  logic [C_W-1:0]   cnt_r;
  logic             neg_r, busy_r;
  logic [COV_W:0]   trial;
  logic [COV_W:0]   diff;
  logic [OUT_W-1:0] kmag;

  assign trial = {rem_r[COV_W-1:0], n_r[N_W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      n_r    <= {(num[COV_W-1] ? COV_W'(-num) : num), {FRAC{1'b0}}};
      neg_r  <= num[COV_W-1];
      d_r    <= den;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      n_r <= n_r << 1;
      if (!diff[COV_W]) begin
        rem_r <= diff;
        q_r   <= {q_r[N_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[N_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == C_W'(N_W - 1)) busy_r <= 1'b0;
    end
  end

  // Saturate to +-(2^31-1)
  assign kmag = (q_r[N_W-1:OUT_W-1] != '0) ? {1'b0, {(OUT_W-1){1'b1}}} : q_r[OUT_W-1:0];
  assign busy = busy_r;
  assign quo  = neg_r ? OUT_W'(-kmag) : OUT_W'(kmag);
endmodule

[hdl/kalman_filter_const_velocity_core.sv]
// Top level: two-state constant-velocity Kalman filter with serial arithmetic.
// After its transfer, an item passes through one predict state, then two 56-step serial
// divisions for the gains. Then come five 32-step bit-serial multiplications, all run one
// after another on one divider and one multiplier. A last state, ST_DONE, loads the output
// register. The first item after reset goes straight from idle to that last state, and an
// item whose innovation variance is not positive goes to it straight from the predict state.
// A result waits in the output register. The next item is taken only after that result has
// been transferred.
`timescale 1ns / 1ps
module kalman_filter_const_velocity_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // [SAMPLE_BITS-1:0] measurement
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] position, [63:32] velocity
  input  logic        cfg_we,
  input  logic [kfcv_pkg::IDX_W-1:0] cfg_index,
  input  logic [kfcv_pkg::REG_W-1:0] cfg_wdata
);
  import kfcv_pkg::*;
  localparam int W48 = COV_W + 8;
  localparam int P_W = W48 + OUT_W;
  localparam logic signed [COV_W-1:0] CMAX = {1'b0, {(COV_W-1){1'b1}}};
  localparam logic signed [COV_W-1:0] CMIN = {1'b1, {(COV_W-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [REG_W-1:0] qn_r, rn_r;
  logic signed [OUT_W-1:0] pos_r, vel_r, k0_r, k1_r;
  logic signed [COV_W-1:0] cpp_r, cpv_r, cvv_r, ppp_r, ppv_r, pvv_r, s_r;
  logic signed [COV_W-1:0] s_w;
  logic signed [W48-1:0] e_r;
  logic started_r, out_v_r;
  logic [63:0] out_d_r;

  // ---- saturation helpers
  function automatic logic signed [COV_W-1:0] csat(input logic signed [P_W-1:0] v);
    if (v > P_W'(CMAX)) return CMAX;
    else if (v < P_W'(CMIN)) return CMIN;
    else return v[COV_W-1:0];
  endfunction
  function automatic logic signed [OUT_W-1:0] osat(input logic signed [P_W-1:0] v);
    if (v > P_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) return {1'b0, {(OUT_W-1){1'b1}}};
    else if (v < P_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) return {1'b1, {(OUT_W-1){1'b0}}};
    else return v[OUT_W-1:0];
  endfunction
  function automatic logic signed [P_W-1:0] mq(input logic signed [P_W-1:0] v);
    // mulq saturates to +-(2^62-1)
    localparam logic signed [P_W-1:0] WM = P_W'(64'sh3FFFFFFFFFFFFFFF);
    if (v > WM) return WM;
    else if (v < -WM) return -WM;
    else return v;
  endfunction

  // ---- measurement scaling
  logic signed [SAMPLE_BITS-1:0] meas;
  logic signed [W48-1:0] zs;
  assign meas = in_tdata[SAMPLE_BITS-1:0];
  assign zs   = W48'(meas) <<< FRAC_BITS;

  // ---- shared units
  logic mstart, dstart, mbusy, dbusy;
  logic signed [W48-1:0] ma;
  logic signed [OUT_W-1:0] mb;
  logic signed [P_W-1:0] mprod;
  logic signed [COV_W-1:0] dnum;
  logic signed [OUT_W-1:0] dq;
  mul_ctl_t mctl;

  kfcv_mul #(.A_W(W48), .B_W(OUT_W), .FRAC(FRAC_BITS)) u_mul (
    .clk, .rst_n, .start(mstart), .a(ma), .b(mb), .busy(mbusy), .prod(mprod));
  kfcv_div #(.FRAC(FRAC_BITS)) u_div (
    .clk, .rst_n, .start(dstart), .num(dnum), .den(s_r), .busy(dbusy), .quo(dq));

  assign mctl.start = mstart;
  assign mctl.busy  = mbusy;

  logic go, unit_busy;
  logic phase_r;  // 0: launch unit, 1: wait
  assign go        = in_tvalid && in_tready;
  assign unit_busy = mctl.busy || dbusy || mctl.start || dstart;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;

  // ---- innovation variance from the predicted covariance
  assign s_w = csat(P_W'(ppp_r) + P_W'(rn_r));

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (go) state_nxt = started_r ? ST_PRED : ST_DONE;
      ST_PRED: state_nxt = (s_w > 0) ? ST_DIV0 : ST_DONE;
      ST_DIV0, ST_DIV1, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4:
        if (phase_r && !unit_busy) state_nxt = state_t'(state_r + 1'b1);
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- unit launch and operand selection
  always_comb begin
    dstart = 1'b0;
    mstart = 1'b0;
    dnum   = ppp_r;
    ma     = e_r;
    mb     = k0_r;
    case (state_r)
      ST_DIV0: dstart = !phase_r;
      ST_DIV1: begin dstart = !phase_r; dnum = ppv_r; end
      ST_MUL0: mstart = !phase_r;
      ST_MUL1: begin mstart = !phase_r; mb = k1_r; end
      ST_MUL2: begin mstart = !phase_r; ma = W48'(ppp_r); end
      ST_MUL3: begin mstart = !phase_r; ma = W48'(ppv_r); end
      ST_MUL4: begin mstart = !phase_r; ma = W48'(ppv_r); mb = k1_r; end
      default: ;
    endcase
  end

  // ---- predict terms
  logic signed [P_W-1:0] pp_w, pv_w, vv_w, xp_w;
  assign pp_w = P_W'(cpp_r) + (P_W'(cpv_r) <<< 1) + P_W'(cvv_r) + P_W'(qn_r);
  assign pv_w = P_W'(cpv_r) + P_W'(cvv_r);
  assign vv_w = P_W'(cvv_r) + P_W'(qn_r);
  assign xp_w = P_W'(pos_r) + P_W'(vel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= 1'b0;
      started_r <= 1'b0;
      out_v_r   <= 1'b0;
      qn_r      <= REG_W'(131072);
      rn_r      <= REG_W'(655360);
      pos_r <= '0; vel_r <= '0;
      cpp_r <= '0; cpv_r <= '0; cvv_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) phase_r <= 1'b0;
      else if (dstart || mstart) phase_r <= 1'b1;
      if (cfg_we) begin
        if (cfg_index == REG_PROC_NOISE) qn_r <= cfg_wdata;
        else if (cfg_index == REG_MEAS_NOISE) rn_r <= cfg_wdata;
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (go) begin
        ppp_r <= csat(pp_w);
        ppv_r <= csat(pv_w);
        pvv_r <= csat(vv_w);
        e_r   <= zs - W48'(osat(xp_w));
        if (!started_r) begin
          started_r <= 1'b1;
          pos_r <= osat(P_W'(zs));
          vel_r <= '0;
        end else pos_r <= osat(xp_w);  // predicted position held here
      end
      if (state_r == ST_PRED) begin
        s_r <= s_w;
        if (s_w <= 0) begin
          cpp_r <= ppp_r; cpv_r <= ppv_r; cvv_r <= pvv_r;
        end
      end
      if (phase_r && !unit_busy) begin
        case (state_r)
          ST_DIV0: k0_r <= dq;
          ST_DIV1: k1_r <= dq;
          ST_MUL0: pos_r <= osat(P_W'(pos_r) + mq(mprod));
          ST_MUL1: vel_r <= osat(P_W'(vel_r) + mq(mprod));
          ST_MUL2: cpp_r <= csat(P_W'(ppp_r) - mq(mprod));
          ST_MUL3: cpv_r <= csat(P_W'(ppv_r) - mq(mprod));
          ST_MUL4: cvv_r <= csat(P_W'(pvv_r) - mq(mprod));
          default: ;
        endcase
      end
      if (state_r == ST_DONE) begin
        out_v_r <= 1'b1;
        out_d_r <= {vel_r, pos_r};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // ---- checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mbusy && dbusy)) else $error("units overlap");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_tvalid) else $error("result lost");
endmodule
